@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_PROP(label, !(cond), msg)

`endif

@@ src/ppw_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed pixel window package
// Types, sizes, codes and helper functions shared by the pixel access block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ppw_pkg;

    localparam int STORE_BYTES = 65536;
    localparam int COORD_BITS  = 16;
    localparam int PIXEL_BITS  = 32;
    localparam int BPP_BITS    = 6;
    localparam int CFG_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;

    localparam int ADDR_BITS   = $clog2(STORE_BYTES);
    localparam int LANES       = PIXEL_BITS / 8;
    localparam int LANE_BITS   = $clog2(LANES);
    localparam int WORD_BITS   = ADDR_BITS - LANE_BITS;
    localparam int WORD_DEPTH  = (STORE_BYTES + LANES - 1) / LANES;
    localparam int NB_BITS     = LANE_BITS + 1;
    localparam int SUB_BITS    = 3;

    localparam int FB_BITS     = COORD_BITS + 2;
    localparam int ROW_BITS    = FB_BITS + 1;
    localparam int PROD_BITS   = ROW_BITS + COORD_BITS;
    localparam int IDX_BITS    = PROD_BITS + 1;

    localparam logic [CFG_IDX_BITS-1:0] REG_BPP    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LEFT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOP    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOTTOM = 3'd4;

    localparam logic [BPP_BITS-1:0] BPP_RESET = 6'd8;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OUTSIDE = 2'd1;
    localparam logic [1:0] ST_BEYOND  = 2'd2;

    localparam logic FUNC_WRITE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_MUL,
        S_IDX,
        S_ISSUE,
        S_MERGE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        DEPTH_1,
        DEPTH_2,
        DEPTH_4,
        DEPTH_8,
        DEPTH_16,
        DEPTH_24,
        DEPTH_32
    } depth_t;

    typedef struct packed {
        logic rd_en;
        logic wr_full;
        logic wr_merge;
    } lane_ctrl_t;

    function automatic depth_t decode_depth(input logic [BPP_BITS-1:0] bpp);
        depth_t d;
        unique case (bpp)
            6'd1:    d = DEPTH_1;
            6'd2:    d = DEPTH_2;
            6'd4:    d = DEPTH_4;
            6'd16:   d = DEPTH_16;
            6'd24:   d = DEPTH_24;
            6'd32:   d = DEPTH_32;
            default: d = DEPTH_8;
        endcase
        return d;
    endfunction

    function automatic logic is_sub_byte(input depth_t d);
        return (d == DEPTH_1) || (d == DEPTH_2) || (d == DEPTH_4);
    endfunction

    function automatic logic [NB_BITS-1:0] pixel_bytes(input depth_t d);
        logic [NB_BITS-1:0] nb;
        unique case (d)
            DEPTH_16: nb = NB_BITS'(2);
            DEPTH_24: nb = NB_BITS'(3);
            DEPTH_32: nb = NB_BITS'(4);
            default:  nb = NB_BITS'(1);
        endcase
        return nb;
    endfunction

    // Byte that holds column c: floor(c * depth / 8).
    function automatic logic [FB_BITS-1:0] floor_byte(input logic [COORD_BITS-1:0] c,
                                                      input depth_t d);
        logic [FB_BITS-1:0] cw;
        logic [FB_BITS-1:0] fb;
        cw = FB_BITS'(c);
        unique case (d)
            DEPTH_1:  fb = cw >> 3;
            DEPTH_2:  fb = cw >> 2;
            DEPTH_4:  fb = cw >> 1;
            DEPTH_16: fb = cw << 1;
            DEPTH_24: fb = (cw << 1) + cw;
            DEPTH_32: fb = cw << 2;
            default:  fb = cw;
        endcase
        return fb;
    endfunction

endpackage

@@ src/ppw_ram.sv @@
// ----------------------------------------------------------------------------
// Single port RAM
// Synchronous RAM with one address, one write port and registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppw_ram #(
    parameter int DATA_BITS = 8,
    parameter int ADDR_BITS = 14,
    parameter int DEPTH     = 16384
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [DATA_BITS-1:0] wdata,
    output logic [DATA_BITS-1:0] rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ src/ppw_index.sv @@
// ----------------------------------------------------------------------------
// Pixel byte index pipeline
// Three register stages: window check, row offset multiply, index add and bound.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppw_index
    import ppw_pkg::*;
(
    input  logic                  clk,
    input  depth_t                depth,
    input  logic [COORD_BITS-1:0] left_x,
    input  logic [COORD_BITS-1:0] top_y,
    input  logic [COORD_BITS-1:0] right_x,
    input  logic [COORD_BITS-1:0] bottom_y,
    input  logic [COORD_BITS-1:0] pos_x,
    input  logic [COORD_BITS-1:0] pos_y,
    output logic [ADDR_BITS-1:0]  idx,
    output logic [1:0]            idx_status
);

    logic                  outside_reg;
    logic                  outside_next;
    logic [FB_BITS-1:0]    dfx_reg;
    logic [FB_BITS-1:0]    dfx_next;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;
    logic [COORD_BITS-1:0] dy_reg;
    logic [COORD_BITS-1:0] dy_next;

    logic                  outside2_reg;
    logic [FB_BITS-1:0]    dfx2_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [PROD_BITS-1:0]  prod_next;

    logic [ADDR_BITS-1:0]  idx_reg;
    logic [ADDR_BITS-1:0]  idx_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;

    logic [FB_BITS-1:0]    fb_left;
    logic [IDX_BITS-1:0]   idx_sum;
    logic [IDX_BITS-1:0]   idx_last;
    logic [NB_BITS-1:0]    nb;

    always_comb
    begin
        nb           = pixel_bytes(depth);
        fb_left      = floor_byte(left_x, depth);
        outside_next = (pos_x < left_x) || (pos_x > right_x) ||
                       (pos_y < top_y) || (pos_y > bottom_y);
        dfx_next     = floor_byte(pos_x, depth) - fb_left;
        row_next     = ROW_BITS'(floor_byte(right_x, depth)) - ROW_BITS'(fb_left)
                       + ROW_BITS'(nb);
        dy_next      = pos_y - top_y;
    end

    always_comb
    begin
        prod_next = PROD_BITS'(row_reg) * PROD_BITS'(dy_reg);
    end

    always_comb
    begin
        idx_sum  = IDX_BITS'(dfx2_reg) + IDX_BITS'(prod_reg);
        idx_last = idx_sum + IDX_BITS'(nb) - IDX_BITS'(1);
        idx_next = idx_sum[ADDR_BITS-1:0];
        if (outside2_reg)
        begin
            status_next = ST_OUTSIDE;
        end
        else if (idx_last >= IDX_BITS'(STORE_BYTES))
        begin
            status_next = ST_BEYOND;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        outside_reg  <= outside_next;
        dfx_reg      <= dfx_next;
        row_reg      <= row_next;
        dy_reg       <= dy_next;
        outside2_reg <= outside_reg;
        dfx2_reg     <= dfx_reg;
        prod_reg     <= prod_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
    end

    assign idx        = idx_reg;
    assign idx_status = status_reg;

endmodule

@@ src/ppw_lanes.sv @@
// ----------------------------------------------------------------------------
// Byte lane pixel store
// Four byte-wide RAM lanes; steers pixel bytes by address and merges sub-byte writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ppw_lanes
    import ppw_pkg::*;
(
    input  logic                  clk,
    input  lane_ctrl_t            lane_ctrl,
    input  depth_t                depth,
    input  logic [ADDR_BITS-1:0]  idx,
    input  logic [SUB_BITS-1:0]   pos_x_low,
    input  logic [PIXEL_BITS-1:0] write_value,
    output logic [PIXEL_BITS-1:0] read_value
);

    logic [LANE_BITS-1:0] off;
    logic [NB_BITS-1:0]   nb;
    logic [LANE_BITS-1:0] lane_k     [LANES];
    logic [WORD_BITS-1:0] lane_addr  [LANES];
    logic                 lane_we    [LANES];
    logic [7:0]           lane_wdata [LANES];
    logic [7:0]           lane_rdata [LANES];
    logic [7:0]           wbyte      [LANES];
    logic [7:0]           pbyte      [LANES];
    logic [SUB_BITS-1:0]  shift;
    logic [7:0]           mask;
    logic [7:0]           merged;

    assign off = idx[LANE_BITS-1:0];
    assign nb  = pixel_bytes(depth);

    always_comb
    begin
        case (depth)
            DEPTH_1:
            begin
                shift = ~pos_x_low;
                mask  = 8'h01;
            end
            DEPTH_2:
            begin
                shift = {~pos_x_low[1:0], 1'b0};
                mask  = 8'h03;
            end
            DEPTH_4:
            begin
                shift = {~pos_x_low[0], 2'b00};
                mask  = 8'h0F;
            end
            default:
            begin
                shift = '0;
                mask  = 8'hFF;
            end
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            wbyte[k] = write_value[8*k +: 8];
            pbyte[k] = lane_rdata[LANE_BITS'(k) + off];
        end
        merged = (pbyte[0] & ~(mask << shift)) | ((write_value[7:0] & mask) << shift);
    end

    always_comb
    begin
        read_value = '0;
        if (is_sub_byte(depth))
        begin
            read_value = PIXEL_BITS'((pbyte[0] >> shift) & mask);
        end
        else
        begin
            for (int k = 0; k < LANES; k++)
            begin
                if (NB_BITS'(k) < nb)
                begin
                    read_value[8*k +: 8] = pbyte[k];
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        assign lane_k[l]     = LANE_BITS'(l) - off;
        assign lane_addr[l]  = idx[ADDR_BITS-1:LANE_BITS]
                               + WORD_BITS'(LANE_BITS'(l) < off);
        assign lane_we[l]    = (lane_ctrl.wr_full && ({1'b0, lane_k[l]} < nb)) ||
                               (lane_ctrl.wr_merge && (lane_k[l] == '0));
        assign lane_wdata[l] = lane_ctrl.wr_merge ? merged : wbyte[lane_k[l]];

        ppw_ram #(
            .DATA_BITS (8),
            .ADDR_BITS (WORD_BITS),
            .DEPTH     (WORD_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (lane_we[l]),
            .re    (lane_ctrl.rd_en),
            .addr  (lane_addr[l]),
            .wdata (lane_wdata[l]),
            .rdata (lane_rdata[l])
        );
    end

endmodule

@@ src/packed_pixel_window_access.sv @@
// ----------------------------------------------------------------------------
// Packed pixel window access
// Reads or writes one packed pixel of a bitmap window held in a byte store.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Beat
//  command   start / busy         func, pos_x, pos_y, write_value
//  result    done (one cycle)     pixel_value, status
//  config    cfg_write            cfg_index, cfg_data
//
//  A command beat is taken when start is high and busy is low.
//  After the command beat the block steps through S_WIN, S_MUL, S_IDX and
//  S_ISSUE; the result beat then shows in S_DONE for a failed access or a
//  write of 8 bits or more, and after S_MERGE for a read or a sub-byte write,
//  which take one extra RAM read before the merge or the return. busy drops
//  during the result cycle, so no new beat is taken before the last result shows.
//  The receiver cannot stall the result. Reset clears the state and the config
//  registers; the pixel store has no reset and is valid only where written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module packed_pixel_window_access
    import ppw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    func,
    input  logic [COORD_BITS-1:0]   pos_x,
    input  logic [COORD_BITS-1:0]   pos_y,
    input  logic [PIXEL_BITS-1:0]   write_value,
    output logic                    done,
    output logic [PIXEL_BITS-1:0]   pixel_value,
    output logic [1:0]              status,
    input  logic                    cfg_write,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    state_t                 state_reg;
    state_t                 state_next;

    logic [BPP_BITS-1:0]    bpp_reg;
    logic [COORD_BITS-1:0]  left_x_reg;
    logic [COORD_BITS-1:0]  top_y_reg;
    logic [COORD_BITS-1:0]  right_x_reg;
    logic [COORD_BITS-1:0]  bottom_y_reg;

    logic                   func_reg;
    logic [COORD_BITS-1:0]  pos_x_reg;
    logic [COORD_BITS-1:0]  pos_y_reg;
    logic [PIXEL_BITS-1:0]  write_value_reg;

    logic [PIXEL_BITS-1:0]  pixel_value_reg;
    logic [PIXEL_BITS-1:0]  pixel_value_next;
    logic [1:0]             status_reg;
    logic [1:0]             status_next;

    depth_t                 depth;
    logic                   accept;
    logic                   is_write;
    logic [ADDR_BITS-1:0]   idx;
    logic [1:0]             idx_status;
    logic [PIXEL_BITS-1:0]  read_value;
    lane_ctrl_t             lane_ctrl;

    assign depth    = decode_depth(bpp_reg);
    assign accept   = start && !busy;
    assign is_write = (func_reg == FUNC_WRITE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg      <= BPP_RESET;
            left_x_reg   <= '0;
            top_y_reg    <= '0;
            right_x_reg  <= '0;
            bottom_y_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BPP:    bpp_reg      <= cfg_data[BPP_BITS-1:0];
                REG_LEFT:   left_x_reg   <= cfg_data;
                REG_TOP:    top_y_reg    <= cfg_data;
                REG_RIGHT:  right_x_reg  <= cfg_data;
                REG_BOTTOM: bottom_y_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg        <= func;
            pos_x_reg       <= pos_x;
            pos_y_reg       <= pos_y;
            write_value_reg <= write_value;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  state_next = accept ? S_WIN : S_IDLE;
            S_WIN:   state_next = S_MUL;
            S_MUL:   state_next = S_IDX;
            S_IDX:   state_next = S_ISSUE;
            S_ISSUE:
            begin
                if (idx_status != ST_OK)
                begin
                    state_next = S_DONE;
                end
                else if (is_write && !is_sub_byte(depth))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE: state_next = S_DONE;
            S_DONE:  state_next = accept ? S_WIN : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b1;
        done      = 1'b0;
        lane_ctrl = '0;
        unique case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_ISSUE:
            begin
                lane_ctrl.rd_en   = (idx_status == ST_OK);
                lane_ctrl.wr_full = (idx_status == ST_OK) && is_write &&
                                    !is_sub_byte(depth);
            end
            S_MERGE: lane_ctrl.wr_merge = is_write;
            S_DONE:
            begin
                busy = 1'b0;
                done = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        pixel_value_next = pixel_value_reg;
        status_next      = status_reg;
        if (state_reg == S_ISSUE)
        begin
            pixel_value_next = '0;
            status_next      = idx_status;
        end
        else if (state_reg == S_MERGE)
        begin
            pixel_value_next = is_write ? '0 : read_value;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_value_reg <= pixel_value_next;
        status_reg      <= status_next;
    end

    assign pixel_value = pixel_value_reg;
    assign status      = status_reg;

    ppw_index u_index (
        .clk        (clk),
        .depth      (depth),
        .left_x     (left_x_reg),
        .top_y      (top_y_reg),
        .right_x    (right_x_reg),
        .bottom_y   (bottom_y_reg),
        .pos_x      (pos_x_reg),
        .pos_y      (pos_y_reg),
        .idx        (idx),
        .idx_status (idx_status)
    );

    ppw_lanes u_lanes (
        .clk         (clk),
        .lane_ctrl   (lane_ctrl),
        .depth       (depth),
        .idx         (idx),
        .pos_x_low   (pos_x_reg[SUB_BITS-1:0]),
        .write_value (write_value_reg),
        .read_value  (read_value)
    );

    `ASSERT_PROP(a_fail_zero, (done && status != ST_OK) |-> (pixel_value == '0), "failed access returned data")
    `ASSERT_PROP(a_status_code, done |-> (status == ST_OK || status == ST_OUTSIDE || status == ST_BEYOND), "bad status code")
    `ASSERT_NEVER(a_write_failed, (lane_ctrl.wr_full || lane_ctrl.wr_merge) && (idx_status != ST_OK), "store written on failed access")
    `ASSERT_PROP(a_accept_starts, accept |=> (state_reg == S_WIN), "accepted beat did not start")
    `ASSERT_PROP(a_done_source, (state_reg == S_DONE) |-> ($past(state_reg) == S_ISSUE || $past(state_reg) == S_MERGE), "result without access")

endmodule

@@ tb/packed_pixel_window_access_tb.sv @@
// ----------------------------------------------------------------------------
// Packed pixel window access testbench
// Drives pixel read and write beats into the window access block, predicts
// results from a byte-store image kept here or takes fixed values for directed
// beats, and compares each result beat field by field. A directed sequence
// covers the register extremes, every pixel depth and each error status. Random
// phases follow, each with new window and depth settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packed_pixel_window_access_tb;
    import ppw_pkg::*;

    localparam logic FUNC_READ = ~FUNC_WRITE;
    localparam int unsigned PHASES = 16;
    localparam int unsigned BEATS_PER_PHASE = 50;

    typedef struct {
        logic                  func;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [PIXEL_BITS-1:0] value;
    } pixel_cmd_t;

    typedef struct {
        logic [PIXEL_BITS-1:0] value;
        logic [1:0]            status;
    } pixel_result_t;

    typedef struct {
        logic [1:0]      status;
        longint unsigned idx;
        int unsigned     nbytes;
        int unsigned     depth;
    } pixel_spot_t;

    typedef enum {
        STEP_REG,
        STEP_CMD
    } step_kind_t;

    typedef struct {
        step_kind_t              kind;
        logic [CFG_IDX_BITS-1:0] reg_index;
        logic [CFG_BITS-1:0]     reg_data;
        pixel_cmd_t              cmd;
        bit                      fixed;
        pixel_result_t           want;
    } directed_step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    func = FUNC_READ;
    logic [COORD_BITS-1:0]   pos_x = '0;
    logic [COORD_BITS-1:0]   pos_y = '0;
    logic [PIXEL_BITS-1:0]   write_value = '0;
    logic                    done;
    logic [PIXEL_BITS-1:0]   pixel_value;
    logic [1:0]              status;
    logic                    cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = REG_BPP;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    logic [BPP_BITS-1:0]     depth_reg = BPP_RESET;
    logic [COORD_BITS-1:0]   win_left = '0;
    logic [COORD_BITS-1:0]   win_top = '0;
    logic [COORD_BITS-1:0]   win_right = '0;
    logic [COORD_BITS-1:0]   win_bottom = '0;

    bit [7:0]                frame_mem [0:STORE_BYTES-1];
    bit                      byte_written [0:STORE_BYTES-1];
    pixel_result_t           expected_results [$];
    directed_step_t          directed_steps [$];
    int unsigned             fail_count = 0;
    bit                      idle_on = 1'b1;

    packed_pixel_window_access u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .write_value (write_value),
        .done        (done),
        .pixel_value (pixel_value),
        .status      (status),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int unsigned depth_of(input logic [BPP_BITS-1:0] bpp);
        case (bpp)
            6'd1, 6'd2, 6'd4, 6'd16, 6'd24, 6'd32: return bpp;
            default: return 8;
        endcase
    endfunction

    function automatic longint unsigned column_byte(input logic [COORD_BITS-1:0] c,
                                                    input int unsigned d);
        longint unsigned cw;
        cw = c;
        return (cw * d) >> 3;
    endfunction

    function automatic pixel_spot_t locate_pixel(input logic [COORD_BITS-1:0] x,
                                                 input logic [COORD_BITS-1:0] y);
        pixel_spot_t     s;
        longint unsigned row;
        longint unsigned dy;
        s.depth = depth_of(depth_reg);
        s.nbytes = (s.depth < 8) ? 1 : s.depth / 8;
        s.idx = 0;
        if (x < win_left || x > win_right || y < win_top || y > win_bottom)
        begin
            s.status = ST_OUTSIDE;
        end
        else
        begin
            dy = y - win_top;
            row = column_byte(win_right, s.depth) - column_byte(win_left, s.depth) + s.nbytes;
            s.idx = column_byte(x, s.depth) - column_byte(win_left, s.depth) + row * dy;
            s.status = (s.idx + s.nbytes - 1 >= STORE_BYTES) ? ST_BEYOND : ST_OK;
        end
        return s;
    endfunction

    function automatic pixel_result_t access_pixel(input pixel_cmd_t c);
        pixel_result_t r;
        pixel_spot_t   s;
        int unsigned   per_byte;
        int unsigned   shift;
        int unsigned   a;
        logic [7:0]    mask;
        logic [7:0]    old;
        s = locate_pixel(c.x, c.y);
        r.value = '0;
        r.status = s.status;
        if (s.status == ST_OK)
        begin
            a = int'(s.idx);
            if (s.depth < 8)
            begin
                per_byte = 8 / s.depth;
                shift = s.depth * (per_byte - 1 - (c.x % per_byte));
                mask = 8'((1 << s.depth) - 1);
                old = frame_mem[a];
                if (c.func == FUNC_WRITE)
                    frame_mem[a] = (old & ~(mask << shift)) | ((c.value[7:0] & mask) << shift);
                else
                    r.value = PIXEL_BITS'((old >> shift) & mask);
            end
            else
            begin
                for (int unsigned k = 0; k < s.nbytes; k++)
                begin
                    if (c.func == FUNC_WRITE)
                    begin
                        frame_mem[a + k] = c.value[8 * k +: 8];
                        byte_written[a + k] = 1'b1;
                    end
                    else
                    begin
                        r.value[8 * k +: 8] = frame_mem[a + k];
                    end
                end
            end
        end
        return r;
    endfunction

    // Keeps random beats away from bytes that were never stored.
    function automatic pixel_cmd_t legalize(input pixel_cmd_t c);
        pixel_cmd_t  l;
        pixel_spot_t s;
        bit          blank;
        l = c;
        s = locate_pixel(c.x, c.y);
        blank = 1'b0;
        if (s.status == ST_OK && (c.func == FUNC_READ || s.depth < 8))
        begin
            for (int unsigned k = 0; k < s.nbytes; k++)
            begin
                if (!byte_written[int'(s.idx) + k])
                    blank = 1'b1;
            end
        end
        if (blank && s.depth >= 8)
        begin
            l.func = FUNC_WRITE;
        end
        else if (blank)
        begin
            l.func = FUNC_READ;
            l.x = win_left;
            l.y = win_top;
        end
        return l;
    endfunction

    function automatic pixel_cmd_t random_cmd();
        pixel_cmd_t  c;
        int unsigned pick;
        pick = $urandom_range(99);
        c.func = $urandom_range(1) ? FUNC_WRITE : FUNC_READ;
        c.value = $urandom;
        c.x = $urandom_range(win_left, win_right);
        c.y = $urandom_range(win_top, win_bottom);
        if (pick < 10)
        begin
            c.x = $urandom;
            c.y = $urandom;
        end
        else if (pick < 20)
        begin
            case ($urandom_range(3))
                0: c.x = win_left - 1'b1;
                1: c.x = win_right + 1'b1;
                2: c.y = win_top - 1'b1;
                default: c.y = win_bottom + 1'b1;
            endcase
        end
        else if (pick < 40)
        begin
            c.x = win_left + COORD_BITS'($urandom_range(15));
            c.y = win_top + COORD_BITS'($urandom_range(3));
        end
        return c;
    endfunction

    function automatic directed_step_t reg_step(input logic [CFG_IDX_BITS-1:0] index,
                                                input logic [CFG_BITS-1:0] data);
        directed_step_t s;
        s.kind = STEP_REG;
        s.reg_index = index;
        s.reg_data = data;
        s.cmd = '{FUNC_READ, '0, '0, '0};
        s.fixed = 1'b0;
        s.want = '{'0, ST_OK};
        return s;
    endfunction

    function automatic directed_step_t cmd_step(input logic f,
                                                input logic [COORD_BITS-1:0] x,
                                                input logic [COORD_BITS-1:0] y,
                                                input logic [PIXEL_BITS-1:0] v,
                                                input bit fixed,
                                                input logic [PIXEL_BITS-1:0] want_value,
                                                input logic [1:0] want_status);
        directed_step_t s;
        s = reg_step(REG_BPP, '0);
        s.kind = STEP_CMD;
        s.cmd = '{f, x, y, v};
        s.fixed = fixed;
        s.want = '{want_value, want_status};
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CFG_BITS-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data = data;
        case (index)
            REG_BPP: depth_reg = data[BPP_BITS-1:0];
            REG_LEFT: win_left = data;
            REG_TOP: win_top = data;
            REG_RIGHT: win_right = data;
            REG_BOTTOM: win_bottom = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic issue_cmd(input pixel_cmd_t c, input bit fixed, input pixel_result_t want);
        int unsigned   gap;
        pixel_result_t predicted;
        gap = (idle_on && $urandom_range(99) < 25) ? $urandom_range(1, 8) : 0;
        repeat (gap) @(negedge clk);
        @(negedge clk);
        start = 1'b1;
        func = c.func;
        pos_x = c.x;
        pos_y = c.y;
        write_value = c.value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = access_pixel(c);
        expected_results.push_back(fixed ? want : predicted);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic program_phase(input int unsigned p);
        int unsigned         depth_list [7] = '{1, 2, 4, 8, 16, 24, 32};
        logic [BPP_BITS-1:0] bpp;
        int unsigned         kind;
        int unsigned         w;
        int unsigned         h;
        int unsigned         lx;
        int unsigned         ty;
        int unsigned         rx;
        int unsigned         by;
        if (p % 8 == 7)
        begin
            do
                bpp = BPP_BITS'($urandom);
            while (depth_of(bpp) == bpp);
        end
        else
        begin
            bpp = BPP_BITS'(depth_list[p % 8]);
        end
        case (p)
            0: kind = 6;
            1: kind = 7;
            2: kind = 9;
            3: kind = 8;
            default: kind = $urandom_range(9);
        endcase
        if (kind == 8 && depth_of(bpp) < 8)
            kind = 0;
        w = $urandom_range(1, 48);
        h = $urandom_range(1, 8);
        lx = $urandom_range(0, 65536 - w);
        ty = $urandom_range(0, 65536 - h);
        if (kind == 6)
        begin
            lx = 65536 - w;
            ty = 65536 - h;
        end
        else if (kind == 7)
        begin
            lx = 0;
            ty = 0;
        end
        rx = lx + w - 1;
        by = ty + h - 1;
        if (kind == 8)
        begin
            lx = $urandom_range(0, 255);
            rx = $urandom_range(16'h4000, 16'hFFFF);
            ty = $urandom_range(0, 16'h7FFF);
            by = ty + $urandom_range(4, 16'hFFFF - ty);
        end
        else if (kind == 9 && $urandom_range(1))
        begin
            lx = $urandom_range(1, 65535);
            rx = $urandom_range(0, lx - 1);
        end
        else if (kind == 9)
        begin
            ty = $urandom_range(1, 65535);
            by = $urandom_range(0, ty - 1);
        end
        write_reg(REG_BPP, CFG_BITS'(bpp));
        write_reg(REG_LEFT, CFG_BITS'(lx));
        write_reg(REG_TOP, CFG_BITS'(ty));
        write_reg(REG_RIGHT, CFG_BITS'(rx));
        write_reg(REG_BOTTOM, CFG_BITS'(by));
    endtask

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, value %h status %0d",
                         $time, pixel_value, status);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (pixel_value !== want.value)
                begin
                    $display("%0t: pixel_value mismatch, expected %h, actual %h",
                             $time, want.value, pixel_value);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("packed_pixel_window_access_tb failed");
        $finish;
    end

    initial
    begin
        pixel_cmd_t    c;
        pixel_result_t none;
        none = '{'0, ST_OK};

        directed_steps.push_back(cmd_step(FUNC_WRITE, 0, 0, 32'hFFFF_FFFF, 1, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 1, 32'hFF, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 1, 0, 0, 1, 0, ST_OUTSIDE));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 16'hFFFF, 16'hFFFF, 0, 1, 0, ST_OUTSIDE));
        directed_steps.push_back(reg_step(REG_BPP, 32));
        directed_steps.push_back(reg_step(REG_LEFT, 0));
        directed_steps.push_back(reg_step(REG_TOP, 0));
        directed_steps.push_back(reg_step(REG_RIGHT, 16'hFFFF));
        directed_steps.push_back(reg_step(REG_BOTTOM, 0));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 16383, 0, 32'hFFFF_FFFF, 1, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 16383, 0, 0, 1, 32'hFFFF_FFFF, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 16384, 0, 0, 1, 0, ST_BEYOND));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 16'hFFFF, 0, 32'h1234_5678, 1, 0,
                                          ST_BEYOND));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 0, 0, 32'h89AB_CDEF, 1, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 1, 32'h89AB_CDEF, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 24));
        directed_steps.push_back(cmd_step(FUNC_READ, 21845, 0, 0, 1, 0, ST_BEYOND));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 16));
        directed_steps.push_back(cmd_step(FUNC_READ, 1, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 1));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 1, 0, 32'hFFFF_FFFE, 1, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 1, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 2));
        directed_steps.push_back(cmd_step(FUNC_READ, 3, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 4));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 1, 0, 32'hFFFF_FFF5, 1, 0, ST_OK));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 0));
        directed_steps.push_back(cmd_step(FUNC_READ, 0, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_BPP, 63));
        directed_steps.push_back(cmd_step(FUNC_READ, 1, 0, 0, 0, 0, ST_OK));
        directed_steps.push_back(reg_step(REG_LEFT, 10));
        directed_steps.push_back(reg_step(REG_RIGHT, 5));
        directed_steps.push_back(cmd_step(FUNC_READ, 7, 0, 0, 1, 0, ST_OUTSIDE));
        directed_steps.push_back(reg_step(REG_LEFT, 0));
        directed_steps.push_back(reg_step(REG_TOP, 3));
        directed_steps.push_back(reg_step(REG_BOTTOM, 2));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 2, 3, 32'h0000_0055, 1, 0, ST_OUTSIDE));
        directed_steps.push_back(reg_step(REG_TOP, 2));
        directed_steps.push_back(reg_step(REG_BOTTOM, 16'hFFFF));
        directed_steps.push_back(reg_step(REG_RIGHT, 16'hFFFF));
        directed_steps.push_back(reg_step(REG_BPP, 8));
        directed_steps.push_back(cmd_step(FUNC_WRITE, 0, 3, 32'hA5A5_A5A5, 1, 0, ST_BEYOND));
        directed_steps.push_back(cmd_step(FUNC_READ, 2, 2, 0, 0, 0, ST_OK));

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_REG)
            begin
                wait_results_drained();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_data);
            end
            else
            begin
                issue_cmd(directed_steps[i].cmd, directed_steps[i].fixed, directed_steps[i].want);
            end
        end

        // Sub-byte phases only touch the first bytes, so store them all first.
        wait_results_drained();
        write_reg(REG_BPP, 32);
        write_reg(REG_LEFT, 0);
        write_reg(REG_TOP, 0);
        write_reg(REG_RIGHT, 63);
        write_reg(REG_BOTTOM, 0);
        for (int unsigned x = 0; x < 64; x++)
        begin
            c = '{FUNC_WRITE, COORD_BITS'(x), '0, $urandom};
            issue_cmd(c, 1'b0, none);
        end

        for (int unsigned p = 0; p < PHASES; p++)
        begin
            wait_results_drained();
            program_phase(p);
            idle_on = !(p >= 5 && p <= 7);
            for (int unsigned n = 0; n < BEATS_PER_PHASE; n++)
            begin
                if ($urandom_range(39) == 0)
                    wait_results_drained();
                issue_cmd(legalize(random_cmd()), 1'b0, none);
            end
        end

        wait_results_drained();
        repeat (8) @(negedge clk);
        if (fail_count == 0)
            $display("packed_pixel_window_access_tb passed");
        else
            $display("packed_pixel_window_access_tb failed");
        $finish;
    end

endmodule
